FILE: sv/approximate_substring_search_assert.svh
// Assertion macros shared by the approximate substring search RTL.
`ifndef APPROXIMATE_SUBSTRING_SEARCH_ASSERT_SVH
`define APPROXIMATE_SUBSTRING_SEARCH_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define APSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define APSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/apss_pkg.sv
// Package with sizes, register indexes and the token type of the search chain.
package apss_pkg;

  localparam int MAX_NEEDLE     = 32;
  localparam int POSITION_WIDTH = 16;
  localparam int CHAR_REGS      = 4;
  localparam int ROWS           = (MAX_NEEDLE < 8 * CHAR_REGS) ? MAX_NEEDLE : 8 * CHAR_REGS;
  localparam int DW             = $clog2(ROWS + 1);
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int LEN_W          = 6;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_CHARS_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EDITS  = 3'd5;

  // One haystack symbol travelling down the chain with its bookkeeping.
  typedef struct packed {
    logic                      valid;
    logic [7:0]                sym;
    logic                      start;
    logic                      last;
    logic [POSITION_WIDTH-1:0] pos;
    logic                      ovf;
    logic [DW-1:0]             len_dist;
    logic [DW-1:0]             above;
    logic [DW-1:0]             diag;
  } tok_t;

endpackage

FILE: sv/approximate_substring_search.sv
// Top level: configuration, position counting, systolic cell row and result stage.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | symbol, first, last
//   out_    | output    | out_valid/out_stall| found, end_position, bad_setting, too_long
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One symbol enters per cycle while in_stall is low; a result leaves after its symbol has passed
// the skewed row of cells, one register stage per needle row, and the output register.
// A stalled result freezes the whole row, and the input is stalled with it.
// Reset needs no clearing pass: the first symbol after reset starts a new haystack.
module approximate_substring_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_symbol,
  input  logic                                in_first,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [apss_pkg::POSITION_WIDTH-1:0] out_end_position,
  output logic                                out_bad_setting,
  output logic                                out_too_long,
  input  logic                                cfg_we,
  input  logic [apss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apss_pkg::CFG_W-1:0]          cfg_data
);
  import apss_pkg::*;

  `include "approximate_substring_search_assert.svh"

  logic [CFG_W-1:0]          chars_r [CHAR_REGS];
  logic [LEN_W-1:0]          needle_length_r;
  logic [LEN_W-1:0]          max_edits_r;
  logic [8*CHAR_REGS*8-1:0]  needle_flat;
  logic [DW-1:0]             len_eff;
  logic                      bad;

  logic                      adv;
  logic [POSITION_WIDTH-1:0] pos_r;
  logic                      ovf_r;
  logic                      restart_r;
  logic [POSITION_WIDTH-1:0] pos_base;
  logic                      ovf_base;
  tok_t                      link [ROWS+1];

  logic                      reported_r;
  logic                      reported_eff;
  logic                      hit;
  logic                      miss;
  tok_t                      tok_end;

  logic                      out_valid_r;
  logic                      out_found_r;
  logic [POSITION_WIDTH-1:0] out_end_position_r;
  logic                      out_bad_setting_r;
  logic                      out_too_long_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < CHAR_REGS; r++) begin
        chars_r[r] <= '0;
      end
      needle_length_r <= LEN_W'(24);
      max_edits_r     <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHARS_0:    chars_r[0] <= cfg_data;
        REG_CHARS_1:    chars_r[1] <= cfg_data;
        REG_CHARS_2:    chars_r[2] <= cfg_data;
        REG_CHARS_3:    chars_r[3] <= cfg_data;
        REG_NEEDLE_LEN: needle_length_r <= cfg_data[LEN_W-1:0];
        REG_MAX_EDITS:  max_edits_r <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign needle_flat = {chars_r[3], chars_r[2], chars_r[1], chars_r[0]};
  assign len_eff = (needle_length_r > LEN_W'(ROWS)) ? DW'(ROWS) : needle_length_r[DW-1:0];
  assign bad = (len_eff == '0) || (max_edits_r > LEN_W'(len_eff));

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Position and overflow are fixed per symbol before it enters the row.
  always_comb begin
    pos_base = (in_first || restart_r) ? '0 : pos_r;
    ovf_base = (in_first || restart_r) ? 1'b0 : ovf_r;
    link[0].valid = in_valid;
    link[0].sym   = in_symbol;
    link[0].start = in_first || restart_r;
    link[0].last  = in_last;
    if (pos_base == POS_MAX) begin
      link[0].pos = POS_MAX;
      link[0].ovf = 1'b1;
    end else begin
      link[0].pos = pos_base + 1'b1;
      link[0].ovf = ovf_base;
    end
    link[0].len_dist = '0;
    link[0].above    = '0;
    link[0].diag     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (in_valid && adv) begin
      restart_r <= in_last;
      pos_r     <= link[0].pos;
      ovf_r     <= link[0].ovf;
    end
  end

  for (genvar g = 0; g < ROWS; g++) begin : g_cell
    apss_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .row_idx     (DW'(g + 1)),
      .needle_char (needle_flat[8*g +: 8]),
      .len         (len_eff),
      .tok_in      (link[g]),
      .tok_out     (link[g+1])
    );
  end

  assign tok_end = link[ROWS];

  // Result decision, in symbol order at the end of the row.
  always_comb begin
    reported_eff = tok_end.start ? 1'b0 : reported_r;
    hit = !reported_eff && !bad && (tok_end.pos >= POSITION_WIDTH'(len_eff))
          && (LEN_W'(tok_end.len_dist) <= max_edits_r);
    miss = !hit && tok_end.last && !reported_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok_end.valid && (hit || miss);
      if (tok_end.valid) begin
        reported_r <= tok_end.last ? 1'b0 : (reported_eff || hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_found_r        <= hit;
      out_end_position_r <= hit ? tok_end.pos : '0;
      out_bad_setting_r  <= !hit && bad;
      out_too_long_r     <= tok_end.ovf;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_end_position = out_end_position_r;
  assign out_bad_setting  = out_bad_setting_r;
  assign out_too_long     = out_too_long_r;

  `APSS_ASSERT_IMP(a_found_clean, out_valid && out_found,
                   !out_bad_setting && out_end_position != '0,
                   "found result carries a refusal or zero position")
  `APSS_ASSERT_IMP(a_miss_zero, out_valid && !out_found, out_end_position == '0,
                   "not-found result has a nonzero position")
  `APSS_ASSERT_IMP(a_sat_pos, out_valid && out_found && out_too_long,
                   out_end_position == POS_MAX,
                   "overflowed match does not report the saturated position")
  `APSS_ASSERT_NXT(a_reset_idle, !rst_n, !out_valid, "result valid right after reset")

endmodule

FILE: sv/apss_cell.sv
// One row of the edit-distance column: holds its distance and forwards the symbol.
module apss_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [apss_pkg::DW-1:0] row_idx,
  input  logic [7:0]            needle_char,
  input  logic [apss_pkg::DW-1:0] len,
  input  apss_pkg::tok_t        tok_in,
  output apss_pkg::tok_t        tok_out
);
  import apss_pkg::*;

  logic [DW-1:0] col_r;
  tok_t          tok_r;
  tok_t          tok_nxt;
  logic [DW-1:0] old_eff;
  logic [DW-1:0] min_v;
  logic [DW-1:0] v;

  always_comb begin
    // A new haystack sees this row at its initial value.
    old_eff = tok_in.start ? row_idx : col_r;
    min_v = old_eff;
    if (tok_in.above < min_v) begin
      min_v = tok_in.above;
    end
    if (tok_in.diag < min_v) begin
      min_v = tok_in.diag;
    end
    if (needle_char == tok_in.sym) begin
      v = tok_in.diag;
    end else begin
      v = min_v + 1'b1;
    end
    tok_nxt = tok_in;
    tok_nxt.above = v;
    tok_nxt.diag = old_eff;
    if (row_idx == len) begin
      tok_nxt.len_dist = v;
    end
  end

  // Only the valid bit is reset; the rest of the token is don't-care while invalid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (tok_in.valid) begin
        col_r <= v;
      end
    end
  end

  assign tok_out = tok_r;

endmodule
